[rtl/core/lisl_pkg.sv]
package lisl_pkg;

  // Default capacity of the sequence store
  localparam int DEF_MAX_ITEMS = 64;

  localparam int VALUE_W = 32;
  localparam int POS_W   = 6;
  localparam int SLEN_W  = 7;

  typedef struct packed {
    logic signed [VALUE_W-1:0] value;
    logic                      last_item;
  } lisl_in_t;

  typedef struct packed {
    logic signed [VALUE_W-1:0] element;
    logic [POS_W-1:0]          position;
    logic [SLEN_W-1:0]         seq_length;
    logic                      last_result;
    logic                      overflow;
  } lisl_out_t;

  // Sequencer states
  typedef enum logic [3:0] {
    ST_LOAD = 4'b0001,
    ST_COMP = 4'b0010,
    ST_WALK = 4'b0100,
    ST_EMIT = 4'b1000
  } lisl_state_t;

endpackage

[rtl/core/lisl_cell.sv]
module lisl_cell import lisl_pkg::*; #(
  parameter int INDEX = 0,
  parameter int IW    = 6,
  parameter int LW    = 7,
  parameter int CW    = 7
) (
  input  logic                      clk,
  input  logic                      rst_n,
  // load
  input  logic                      load_we,
  input  logic signed [VALUE_W-1:0] load_val,
  input  logic                      feed_ld,
  input  logic                      feed_shift,
  input  logic signed [VALUE_W-1:0] feed_in,
  output logic signed [VALUE_W-1:0] feed_out,
  input  logic [CW-1:0]             count,
  // probe chain, left to right
  input  logic                      pv_in,
  input  logic signed [VALUE_W-1:0] pval_in,
  input  logic [IW-1:0]             pidx_in,
  input  logic [LW-1:0]             pbest_in,
  output logic                      pv_out,
  output logic signed [VALUE_W-1:0] pval_out,
  output logic [IW-1:0]             pidx_out,
  output logic [LW-1:0]             pbest_out,
  output logic [LW-1:0]             len_wr,
  // walk chain, right to left
  input  logic                      wv_in,
  input  logic [LW-1:0]             wneed_in,
  input  logic signed [VALUE_W-1:0] wprev_in,
  input  logic                      wfirst_in,
  output logic                      wv_out,
  output logic [LW-1:0]             wneed_out,
  output logic signed [VALUE_W-1:0] wprev_out,
  output logic                      wfirst_out,
  input  logic                      sel_clr,
  // emit chain, left to right
  input  logic                      em_in,
  output logic                      em_out,
  output logic                      hit,
  output logic signed [VALUE_W-1:0] hit_val
);

  logic signed [VALUE_W-1:0] value_r, feed_r, pval_r, wprev_r;
  logic [LW-1:0]             len_r, pbest_r, wneed_r;
  logic [IW-1:0]             pidx_r;
  logic                      pv_r, wv_r, wfirst_r, em_r, sel_r;
  logic                      p_end, w_take;

  assign p_end  = pv_in && (pidx_in == IW'(INDEX));
  assign len_wr = p_end ? (pbest_in + LW'(1)) : '0;
  assign w_take = wv_in && (CW'(INDEX) < count) && (len_r == wneed_in) &&
                  (wfirst_in || (value_r < wprev_in));

  // Hold loaded value, computed length and shifting feed copy; register probe and walk data
  always_ff @(posedge clk) begin
    if (load_we) value_r <= load_val;
    if (feed_ld) begin
      feed_r <= load_we ? load_val : value_r;
    end else if (feed_shift) begin
      feed_r <= feed_in;
    end
    if (p_end) len_r <= pbest_in + LW'(1);
    pval_r  <= pval_in;
    pidx_r  <= pidx_in;
    pbest_r <= (pv_in && (value_r < pval_in) && (len_r > pbest_in)) ? len_r : pbest_in;
    wneed_r <= w_take ? (wneed_in - LW'(1)) : wneed_in;
    wprev_r <= w_take ? value_r : wprev_in;
  end

  // Advance the tokens
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pv_r     <= 1'b0;
      wv_r     <= 1'b0;
      wfirst_r <= 1'b0;
      em_r     <= 1'b0;
      sel_r    <= 1'b0;
    end else begin
      pv_r     <= pv_in && !p_end;
      wv_r     <= wv_in;
      wfirst_r <= wfirst_in && !w_take;
      em_r     <= em_in;
      if (sel_clr) begin
        sel_r <= 1'b0;
      end else if (w_take) begin
        sel_r <= 1'b1;
      end
    end
  end

  assign feed_out   = feed_r;
  assign pv_out     = pv_r;
  assign pval_out   = pval_r;
  assign pidx_out   = pidx_r;
  assign pbest_out  = pbest_r;
  assign wv_out     = wv_r;
  assign wneed_out  = wneed_r;
  assign wprev_out  = wprev_r;
  assign wfirst_out = wfirst_r;
  assign em_out     = em_r;
  assign hit        = em_in && sel_r;
  assign hit_val    = value_r;

endmodule

[rtl/core/longest_increasing_subsequence_list_top.sv]
// Channel  Ports                          Handshake
// input    start, busy, in_word           word taken when start && !busy
// result   out_valid, out_word            word shown for one cycle, no stall
//
// Loading takes one word per cycle; the word marked last_item starts the run.
// The probe chain then passes the n loaded words, followed by the backward walk
// and the emit scan over all MAX_ITEMS cells; busy is high for all.
// Each result word follows in the cycle after the scan reaches its cell.
// Reset (rst_n low, synchronous) empties the store; no clearing pass.
module longest_increasing_subsequence_list_top import lisl_pkg::*; #(
  parameter int MAX_ITEMS = DEF_MAX_ITEMS
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  output logic      busy,
  input  lisl_in_t  in_word,
  output logic      out_valid,
  output lisl_out_t out_word
);

  localparam int IW  = $clog2(MAX_ITEMS);
  localparam int CW  = $clog2(MAX_ITEMS + 1);
  localparam int LW  = CW;
  localparam int TW  = CW + 1;
  localparam int N   = MAX_ITEMS;

  lisl_state_t  state_r, state_nxt;
  logic [CW-1:0] count_r, ecnt_r;
  logic [TW-1:0] cyc_r;
  logic [LW-1:0] best_r;
  logic          ovf_r;
  logic          accept, last_acc, out_valid_r;
  lisl_out_t     out_r;

  logic signed [VALUE_W-1:0] feed [N+1];
  logic                      pv   [N+1];
  logic signed [VALUE_W-1:0] pval [N+1];
  logic [IW-1:0]             pidx [N+1];
  logic [LW-1:0]             pbest[N+1];
  logic                      wv   [N+1];
  logic [LW-1:0]             wneed[N+1];
  logic signed [VALUE_W-1:0] wprev[N+1];
  logic                      wfirst[N+1];
  logic                      em   [N+1];
  logic [LW-1:0]             len_wr[N];
  logic [N-1:0]              hit, wr_any;
  logic signed [VALUE_W-1:0] hit_val[N];
  logic [LW-1:0]             wr_or;
  logic signed [VALUE_W-1:0] hv_or;
  logic [IW-1:0]             hp_or;
  logic                      hit_any;

  assign busy     = !state_r[0];
  assign accept   = start && !busy;
  assign last_acc = accept && in_word.last_item;

  // Chain heads
  assign feed[N]   = '0;
  assign pv[0]     = (state_r == ST_COMP) && (cyc_r < TW'(count_r));
  assign pval[0]   = feed[0];
  assign pidx[0]   = cyc_r[IW-1:0];
  assign pbest[0]  = '0;
  assign wv[N]     = (state_r == ST_WALK) && (cyc_r == '0);
  assign wneed[N]  = best_r;
  assign wprev[N]  = '0;
  assign wfirst[N] = 1'b1;
  assign em[0]     = (state_r == ST_EMIT) && (cyc_r == '0);

  for (genvar k = 0; k < N; k++) begin : g_cell
    lisl_cell #(.INDEX(k), .IW(IW), .LW(LW), .CW(CW)) u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .load_we    (accept && (count_r == CW'(k))),
      .load_val   (in_word.value),
      .feed_ld    (last_acc),
      .feed_shift (state_r == ST_COMP),
      .feed_in    (feed[k+1]),
      .feed_out   (feed[k]),
      .count      (count_r),
      .pv_in      (pv[k]),
      .pval_in    (pval[k]),
      .pidx_in    (pidx[k]),
      .pbest_in   (pbest[k]),
      .pv_out     (pv[k+1]),
      .pval_out   (pval[k+1]),
      .pidx_out   (pidx[k+1]),
      .pbest_out  (pbest[k+1]),
      .len_wr     (len_wr[k]),
      .wv_in      (wv[k+1]),
      .wneed_in   (wneed[k+1]),
      .wprev_in   (wprev[k+1]),
      .wfirst_in  (wfirst[k+1]),
      .wv_out     (wv[k]),
      .wneed_out  (wneed[k]),
      .wprev_out  (wprev[k]),
      .wfirst_out (wfirst[k]),
      .sel_clr    (last_acc),
      .em_in      (em[k]),
      .em_out     (em[k+1]),
      .hit        (hit[k]),
      .hit_val    (hit_val[k])
    );
    assign wr_any[k] = pv[k] && (pidx[k] == IW'(k));
  end

  // Gather the single write and the single hit of this cycle
  always_comb begin
    wr_or   = '0;
    hv_or   = '0;
    hp_or   = '0;
    hit_any = |hit;
    for (int k = 0; k < N; k++) begin
      wr_or = wr_or | len_wr[k];
      if (hit[k]) begin
        hv_or = hv_or | hit_val[k];
        hp_or = hp_or | IW'(k);
      end
    end
  end

  // Sequence the phases
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_LOAD: if (last_acc) state_nxt = ST_COMP;
      ST_COMP: if (cyc_r == TW'({count_r, 1'b0} - 2)) state_nxt = ST_WALK;
      ST_WALK: if (cyc_r == TW'(N - 1)) state_nxt = ST_EMIT;
      ST_EMIT: if (cyc_r == TW'(N - 1)) state_nxt = ST_LOAD;
      default: state_nxt = ST_LOAD;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_LOAD;
      count_r     <= '0;
      ovf_r       <= 1'b0;
      cyc_r       <= '0;
      best_r      <= LW'(1);
      ecnt_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cyc_r       <= (state_nxt != state_r) ? '0 : cyc_r + TW'(1);
      out_valid_r <= (state_r == ST_EMIT) && hit_any;
      if (accept) begin
        if (count_r < CW'(N)) begin
          count_r <= count_r + CW'(1);
        end else begin
          ovf_r <= 1'b1;
        end
      end
      if (last_acc) best_r <= LW'(1);
      if ((state_r == ST_COMP) && (wr_or > best_r)) best_r <= wr_or;
      if (state_r == ST_WALK) ecnt_r <= '0;
      if ((state_r == ST_EMIT) && hit_any) ecnt_r <= ecnt_r + CW'(1);
      if ((state_r == ST_EMIT) && (state_nxt == ST_LOAD)) begin
        count_r <= '0;
        ovf_r   <= 1'b0;
      end
    end
  end

  // Register the outgoing word
  always_ff @(posedge clk) begin
    out_r.element     <= hv_or;
    out_r.position    <= POS_W'(hp_or);
    out_r.seq_length  <= SLEN_W'(best_r);
    out_r.last_result <= (ecnt_r + CW'(1)) == CW'(best_r);
    out_r.overflow    <= ovf_r;
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_r;

  a_state_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot(state_r)) else $error("state not one-hot");
  a_one_write: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(wr_any)) else $error("two length writes in one cycle");
  a_out_from_emit: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> $past(state_r == ST_EMIT)) else $error("word outside emit");
  a_emit_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_EMIT) |-> (ecnt_r <= CW'(best_r))) else $error("too many words");

endmodule
